// File: hw/rtl/ppd_pkg.sv
// ppd_pkg: shared widths, reset values and codes for the presence pin debouncer
// no dependencies
`timescale 1ns / 1ps

package ppd_pkg;

  localparam int unsigned TickW = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [TickW-1:0] TickMax = {TickW{1'b1}};

  // register reset values
  localparam logic [TickW-1:0] HoldoffReset = TickW'(70);
  localparam logic [TickW-1:0] InDelayReset = TickW'(100);
  localparam logic [TickW-1:0] OutDelayReset = TickW'(200);
  localparam logic InLevelReset = 1'b1;

  // register indexes
  typedef enum logic [CfgIndexW-1:0] {
    CFG_HOLDOFF   = 2'd0,
    CFG_IN_DELAY  = 2'd1,
    CFG_OUT_DELAY = 2'd2,
    CFG_IN_LEVEL  = 2'd3
  } cfg_index_t;

  // box status codes
  localparam logic [StatusW-1:0] StatusUnknown = 2'd0;
  localparam logic [StatusW-1:0] StatusIn = 2'd1;
  localparam logic [StatusW-1:0] StatusOut = 2'd2;

endpackage

// File: hw/rtl/presence_pin_debouncer.sv
// presence_pin_debouncer: result valid in the cycle after item accept;
// throughput one item per cycle, set by the single output register
// (input stalls only while that register holds an untaken result).
// synchronous active-low reset restores register defaults, clears the timer,
// sets status to unknown and arms the first-tick change.
// depends on ppd_pkg
`timescale 1ns / 1ps

module presence_pin_debouncer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_pin_level,
  input  logic                          in_check_request,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_report_valid,
  output logic [ppd_pkg::StatusW-1:0]   out_box_status,
  output logic                          out_change_accepted,
  input  logic                          cfg_we,
  input  logic [ppd_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [ppd_pkg::CfgDataW-1:0]  cfg_wdata
);

  // configuration
  logic [ppd_pkg::TickW-1:0] holdoff_r;
  logic [ppd_pkg::TickW-1:0] in_delay_r;
  logic [ppd_pkg::TickW-1:0] out_delay_r;
  logic                      in_level_r;

  // debounce state
  logic                        prev_level_r, prev_level_nxt;
  logic                        first_tick_r, first_tick_nxt;
  logic [ppd_pkg::TickW-1:0]   since_r, since_nxt;
  logic [ppd_pkg::TickW-1:0]   settle_r, settle_nxt;
  logic                        running_r, running_nxt;
  logic [ppd_pkg::StatusW-1:0] status_r, status_nxt;

  // result register
  logic                        out_valid_r;
  logic                        report_r, report_nxt;
  logic                        accepted_r;

  logic                      accept;
  logic                      is_in;
  logic [ppd_pkg::TickW-1:0] elapsed;
  logic                      changed;
  logic                      accepted;
  logic [ppd_pkg::TickW-1:0] settle_dec;
  logic [ppd_pkg::TickW-1:0] delay;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign is_in    = (in_pin_level == in_level_r);
  assign elapsed  = (since_r == ppd_pkg::TickMax) ? ppd_pkg::TickMax
                                                  : since_r + ppd_pkg::TickW'(1);
  assign changed  = first_tick_r | (in_pin_level != prev_level_r);
  assign accepted = changed & (first_tick_r | (elapsed >= holdoff_r));
  assign delay    = is_in ? in_delay_r : out_delay_r;

  always_comb begin
    prev_level_nxt = in_pin_level;
    first_tick_nxt = 1'b0;
    since_nxt      = accepted ? '0 : elapsed;
    settle_nxt     = settle_r;
    running_nxt    = running_r;
    status_nxt     = status_r;
    report_nxt     = 1'b0;
    settle_dec     = (settle_r != '0) ? settle_r - ppd_pkg::TickW'(1) : settle_r;
    if (running_r) begin
      settle_nxt = settle_dec;
      if (settle_dec == '0) begin
        running_nxt = 1'b0;
        status_nxt  = is_in ? ppd_pkg::StatusIn : ppd_pkg::StatusOut;
        report_nxt  = 1'b1;
      end
    end
    // restart after expiry so a same-tick expiry is still reported
    if (accepted | in_check_request) begin
      settle_nxt  = (delay == '0) ? ppd_pkg::TickW'(1) : delay;
      running_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holdoff_r   <= ppd_pkg::HoldoffReset;
      in_delay_r  <= ppd_pkg::InDelayReset;
      out_delay_r <= ppd_pkg::OutDelayReset;
      in_level_r  <= ppd_pkg::InLevelReset;
    end else if (cfg_we) begin
      case (ppd_pkg::cfg_index_t'(cfg_index))
        ppd_pkg::CFG_HOLDOFF:   holdoff_r   <= cfg_wdata[ppd_pkg::TickW-1:0];
        ppd_pkg::CFG_IN_DELAY:  in_delay_r  <= cfg_wdata[ppd_pkg::TickW-1:0];
        ppd_pkg::CFG_OUT_DELAY: out_delay_r <= cfg_wdata[ppd_pkg::TickW-1:0];
        ppd_pkg::CFG_IN_LEVEL:  in_level_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= 1'b0;
      first_tick_r <= 1'b1;
      since_r      <= ppd_pkg::TickMax;
      settle_r     <= '0;
      running_r    <= 1'b0;
      status_r     <= ppd_pkg::StatusUnknown;
    end else if (accept) begin
      prev_level_r <= prev_level_nxt;
      first_tick_r <= first_tick_nxt;
      since_r      <= since_nxt;
      settle_r     <= settle_nxt;
      running_r    <= running_nxt;
      status_r     <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      report_r   <= report_nxt;
      accepted_r <= accepted;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_report_valid    = report_r;
  assign out_box_status      = status_r;
  assign out_change_accepted = accepted_r;

endmodule
